@@ src/msjd_pkg.sv @@
// Shared types, widths and codes of the multi-server job dispatcher.
`timescale 1ns / 1ps
package msjd_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int MAX_SERVERS  = 8;
    localparam int ACTIVE_RESET = 3;

    localparam int ID_W      = 16;
    localparam int DUR_W     = 8;
    localparam int KIND_W    = 2;
    localparam int SRV_OUT_W = 3;
    localparam int QC_W      = 7;
    localparam int SERVED_W  = 16;
    localparam int TOTAL_W   = 32;
    localparam int ACT_W     = 4;
    localparam int JOB_W     = ID_W + DUR_W;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int NCNT_W = $clog2(MAX_SERVERS + 1);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE = 2'd0;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0]
    {
        KIND_PUSH     = 2'd0,
        KIND_ASSIGN   = 2'd1,
        KIND_TICK_END = 2'd2
    } kind_t;

    typedef enum logic [1:0]
    {
        B_IDLE,
        B_PREP,
        B_SCAN,
        B_END
    } back_state_t;

    typedef struct packed
    {
        op_t              op;
        logic [ID_W-1:0]  job_id;
        logic [DUR_W-1:0] duration;
    } cmd_t;

    typedef struct packed
    {
        kind_t                kind;
        logic [ID_W-1:0]      job_id;
        logic [SRV_OUT_W-1:0] server;
        logic [DUR_W-1:0]     duration;
        logic                 overflow;
        logic [QC_W-1:0]      queue_count;
        logic [SERVED_W-1:0]  served_count;
        logic [TOTAL_W-1:0]   service_total;
        logic                 last;
    } result_t;

endpackage

@@ src/msjd_front.sv @@
// Front end: accepts input transfers, classifies them and queues commands.
`timescale 1ns / 1ps
module msjd_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [msjd_pkg::IN_TDATA_W-1:0]   in_data,
    input  logic                              in_sel,
    output logic                              cmd_valid,
    output msjd_pkg::cmd_t                    cmd,
    input  logic                              cmd_pop
);

    msjd_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    msjd_pkg::cmd_t in_cmd;

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.op       = msjd_pkg::op_t'(in_sel);
        in_cmd.job_id   = in_data[msjd_pkg::ID_W-1:0];
        in_cmd.duration = in_data[msjd_pkg::ID_W +: msjd_pkg::DUR_W];
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ src/msjd_back.sv @@
// Back end: job queue memory, server countdowns, statistics and result register.
`timescale 1ns / 1ps
module msjd_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [msjd_pkg::ACT_W-1:0]       active_servers,
    input  logic                             cmd_valid,
    input  msjd_pkg::cmd_t                   cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    output msjd_pkg::result_t                out_data,
    input  logic                             out_ready
);

    localparam int PW = msjd_pkg::PTR_W;
    localparam int CW = msjd_pkg::CNT_W;
    localparam int SW = msjd_pkg::SRV_W;
    localparam int NW = msjd_pkg::NCNT_W;
    localparam int DW = msjd_pkg::DUR_W;
    localparam int TW = msjd_pkg::TOTAL_W;
    localparam int VW = msjd_pkg::SERVED_W;

    logic [msjd_pkg::JOB_W-1:0] job_mem [msjd_pkg::QUEUE_DEPTH];
    logic [msjd_pkg::JOB_W-1:0] rd_data_reg;

    msjd_pkg::back_state_t state_reg;
    msjd_pkg::back_state_t state_next;

    logic [PW-1:0]  head_reg;
    logic [PW-1:0]  head_next;
    logic [PW-1:0]  tail_reg;
    logic [PW-1:0]  tail_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [VW-1:0]  served_reg;
    logic [VW-1:0]  served_next;
    logic [TW-1:0]  total_reg;
    logic [TW-1:0]  total_next;
    logic [DW-1:0]  rem_reg [msjd_pkg::MAX_SERVERS];
    logic [DW-1:0]  rem_next [msjd_pkg::MAX_SERVERS];
    logic [SW-1:0]  idx_reg;
    logic [SW-1:0]  idx_next;

    logic              out_valid_reg;
    msjd_pkg::result_t out_data_reg;

    logic              can_emit;
    logic              emit;
    msjd_pkg::result_t res;
    logic              mem_we;
    logic [NW-1:0]     n_srv;
    logic              assign_req;
    logic              last_idx;
    logic [DW-1:0]     rd_dur;
    logic [TW:0]       sum_ext;

    assign can_emit   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign rd_dur     = rd_data_reg[DW-1:0];
    assign sum_ext    = {1'b0, total_reg} + (TW+1)'(rd_dur);
    assign assign_req = (rem_reg[idx_reg] == '0) && (count_reg != '0);
    assign last_idx   = (NW'(idx_reg) + NW'(1)) == n_srv;

    // Clamp the active count to the number of servers built.
    always_comb
    begin
        if (32'(active_servers) > 32'(msjd_pkg::MAX_SERVERS))
        begin
            n_srv = NW'(msjd_pkg::MAX_SERVERS);
        end
        else
        begin
            n_srv = NW'(active_servers);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msjd_pkg::B_IDLE:
            begin
                if (cmd_valid && cmd.op == msjd_pkg::OP_TICK)
                begin
                    state_next = msjd_pkg::B_PREP;
                end
            end
            msjd_pkg::B_PREP:
            begin
                state_next = (n_srv == '0) ? msjd_pkg::B_END : msjd_pkg::B_SCAN;
            end
            msjd_pkg::B_SCAN:
            begin
                if ((!assign_req || can_emit) && last_idx)
                begin
                    state_next = msjd_pkg::B_END;
                end
            end
            msjd_pkg::B_END:
            begin
                if (can_emit)
                begin
                    state_next = msjd_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = msjd_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        served_next = served_reg;
        total_next  = total_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        emit        = 1'b0;
        res         = '0;
        case (state_reg)
            msjd_pkg::B_IDLE:
            begin
                idx_next = '0;
                if (cmd_valid)
                begin
                    if (cmd.op == msjd_pkg::OP_PUSH)
                    begin
                        if (can_emit)
                        begin
                            cmd_pop  = 1'b1;
                            emit     = 1'b1;
                            res.kind = msjd_pkg::KIND_PUSH;
                            res.last = 1'b1;
                            if (count_reg >= CW'(msjd_pkg::QUEUE_DEPTH))
                            begin
                                res.overflow = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                tail_next  = (tail_reg == PW'(msjd_pkg::QUEUE_DEPTH - 1)) ?
                                             '0 : tail_reg + PW'(1);
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        cmd_pop = 1'b1;
                    end
                end
            end
            msjd_pkg::B_PREP:
            begin
                idx_next = '0;
            end
            msjd_pkg::B_SCAN:
            begin
                if (assign_req)
                begin
                    // Hold on this server until the result register frees up.
                    if (can_emit)
                    begin
                        emit             = 1'b1;
                        head_next        = (head_reg == PW'(msjd_pkg::QUEUE_DEPTH - 1)) ?
                                           '0 : head_reg + PW'(1);
                        count_next       = count_reg - CW'(1);
                        rem_next[idx_reg] = rd_dur;
                        served_next      = (served_reg == '1) ? served_reg
                                                              : served_reg + VW'(1);
                        total_next       = sum_ext[TW] ? '1 : sum_ext[TW-1:0];
                        res.kind         = msjd_pkg::KIND_ASSIGN;
                        res.job_id       = rd_data_reg[msjd_pkg::JOB_W-1:DW];
                        res.server       = msjd_pkg::SRV_OUT_W'(idx_reg);
                        res.duration     = rd_dur;
                        idx_next         = idx_reg + SW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            msjd_pkg::B_END:
            begin
                if (can_emit)
                begin
                    emit     = 1'b1;
                    res.kind = msjd_pkg::KIND_TICK_END;
                    res.last = 1'b1;
                    for (int i = 0; i < msjd_pkg::MAX_SERVERS; i++)
                    begin
                        if (NW'(i) < n_srv && rem_reg[i] != '0)
                        begin
                            rem_next[i] = rem_reg[i] - DW'(1);
                        end
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
        res.queue_count   = msjd_pkg::QC_W'(count_next);
        res.served_count  = served_next;
        res.service_total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msjd_pkg::B_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            served_reg    <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < msjd_pkg::MAX_SERVERS; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            served_reg <= served_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            rem_reg    <= rem_next;
            if (can_emit)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && can_emit)
        begin
            out_data_reg <= res;
        end
    end

    // Read port follows the next head, so the head job is ready each scan cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_mem[tail_reg] <= {cmd.job_id, cmd.duration};
        end
        rd_data_reg <= job_mem[head_next];
    end

endmodule

@@ src/multi_server_job_dispatcher_core.sv @@
// Top level of the multi-server job dispatcher: config register, front and back.
//
//  channel  dir  handshake                       payload
//  s_*      in   s_tvalid / s_tready             s_tdata, s_tuser (op)
//  m_*      out  m_tvalid / m_tready             m_tdata, m_tuser (kind), m_tlast
//  apb      in   psel / penable / pready         paddr, pwrite, pwdata, prdata
//
//  A push is handled in the back end's idle state. A tick steps through the states in
//  order: idle takes the command, prep reads the queue head, scan visits each of the n
//  clamped active servers in turn, end emits the tick end and steps the countdowns.
//  The front holds two commands, so input transfers continue while the back works.
//  A stalled m_tready holds the scan on the current server; no results are lost.
//  Reset clears queue pointers, countdowns and statistics at once; active_servers = 3.
`timescale 1ns / 1ps
module multi_server_job_dispatcher_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [msjd_pkg::IN_TDATA_W-1:0]     s_tdata,   // job_id[15:0], duration[23:16]
    input  logic [0:0]                          s_tuser,   // op[0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // job_id_out[15:0], server[18:16], duration_out[26:19], overflow[27],
    // queue_count[34:28], served_count[50:35], service_total[82:51], zero[87:83]
    output logic [msjd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [msjd_pkg::KIND_W-1:0]         m_tuser,   // kind[1:0]
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msjd_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [msjd_pkg::ACT_W-1:0] active_reg;
    logic                       cfg_write;
    logic                       cmd_valid;
    msjd_pkg::cmd_t             cmd;
    logic                       cmd_pop;
    msjd_pkg::result_t          result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == msjd_pkg::ADDR_ACTIVE);
    assign prdata    = (paddr == msjd_pkg::ADDR_ACTIVE) ? 32'(active_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= msjd_pkg::ACT_W'(msjd_pkg::ACTIVE_RESET);
        end
        else if (cfg_write)
        begin
            active_reg <= pwdata[msjd_pkg::ACT_W-1:0];
        end
    end

    msjd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_sel    (s_tuser[0]),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    msjd_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_servers (active_reg),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .out_valid      (m_tvalid),
        .out_data       (result),
        .out_ready      (m_tready)
    );

    assign m_tuser = result.kind;
    assign m_tlast = result.last;
    assign m_tdata = {5'd0, result.service_total, result.served_count, result.queue_count,
                      result.overflow, result.duration, result.server, result.job_id};

endmodule

@@ src/msjd_checker.sv @@
// Port-level checks of the job dispatcher result stream, bound to the top level.
`timescale 1ns / 1ps
module msjd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [msjd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic [msjd_pkg::KIND_W-1:0]         m_tuser,
    input  logic                                m_tlast
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_push_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == msjd_pkg::KIND_PUSH |-> m_tlast && m_tdata[26:0] == 27'd0)
        else $error("push acknowledge not a lone, empty result");

    a_assign_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == msjd_pkg::KIND_ASSIGN |-> !m_tlast && !m_tdata[27])
        else $error("assignment marked last or overflow");

    a_served_mono: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && $past(m_tvalid) |-> m_tdata[50:35] >= $past(m_tdata[50:35]))
        else $error("served count went down");

endmodule

bind multi_server_job_dispatcher_core msjd_checker u_msjd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
